/* hw/rtl/etd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etd_pkg: shared types and constants for epoch_seconds_to_datetime
// Field widths, reciprocal constants for the constant divisions, month table.
// ----------------------------------------------------------------------------
package etd_pkg;

  // field widths
  localparam int unsigned SECS_W  = 32;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned MDAY_W  = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // internal widths
  localparam int unsigned DAYS_W  = 16;  // whole days since epoch, max 49710
  localparam int unsigned TOD_W   = 17;  // seconds of day, max 86399
  localparam int unsigned DNUM_W  = 18;  // 4 * adjusted days + 2
  localparam int unsigned YOFF_W  = 8;   // years since 1970, max 136
  localparam int unsigned DOY_W   = 9;   // day of year, 0..365
  localparam int unsigned TMIN_W  = 11;  // minutes of day, max 1439

  // 86400 = 2^7 * 675: shift, then multiply by ceil(2^35 / 675)
  localparam int unsigned DAY_SHIFT     = 7;
  localparam int unsigned DAY_ODD_W     = 10;
  localparam logic [DAY_ODD_W-1:0] DAY_ODD = 10'd675;
  localparam int unsigned DAY_RECIP_W   = 26;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 26'd50903317;
  localparam int unsigned DAY_RECIP_SH  = 35;

  // 2100 is not a leap year: a phantom Feb 29 is inserted from 2100-03-01 on,
  // so the plain 4-year rule holds across the whole input range
  localparam logic [DAYS_W-1:0] DAY_2100_MAR1 = 16'd47541;

  // year split: n = 4*d + 2, year = n / 1461, day of year = (n % 1461) / 4
  localparam int unsigned Y4_W        = 11;
  localparam logic [Y4_W-1:0] DAYS_4Y = 11'd1461;
  localparam int unsigned Y4_RECIP_W  = 19;
  localparam logic [Y4_RECIP_W-1:0] Y4_RECIP = 19'd367469;  // ceil(2^29 / 1461)
  localparam int unsigned Y4_RECIP_SH = 29;

  // time of day
  localparam int unsigned TRECIP_W     = 18;
  localparam logic [TRECIP_W-1:0] HOUR_RECIP = 18'd149131;  // ceil(2^29 / 3600)
  localparam int unsigned HOUR_RECIP_SH = 29;
  localparam logic [TRECIP_W-1:0] MIN_RECIP  = 18'd139811;  // ceil(2^23 / 60)
  localparam int unsigned MIN_RECIP_SH  = 23;
  localparam logic [5:0] SIXTY = 6'd60;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;

  // first day of each month in a common year; +1 from March in a leap year
  localparam logic [DOY_W-1:0] MONTH_START [0:11] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // per-stage load enables for the inner pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } etd_adv_t;

endpackage

/* hw/rtl/epoch_seconds_to_datetime.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_datetime: Unix seconds to Gregorian UTC date and time
// Streams unsigned 32-bit epoch seconds in, calendar date and time of day out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one word per timestamp (tdata = unix_seconds).
//   Master stream gives one word per timestamp, in order, with year, month,
//   day of month, hour, minute and second packed from the low bit up.
//   A word is moved when tvalid and tready are both high at a rising edge.
// Pipeline: a result passes the input register, four arithmetic stages
//   and the output register, in order.
// Throughput: one word per cycle while the output is taken. Each stage holds
//   only constant-coefficient multiplies; the stage count sets the latency only.
// Stall: each stage loads when empty or when the stage after it moves, so
//   bubbles collapse and input keeps flowing while a result waits; with the
//   output held and every stage full, s_axis_tready drops.
// Reset: rst_ni clears the stage valid bits at once; the pipe comes up empty
//   and s_axis_tready is high in the first cycle after reset.
// Range: every 32-bit input is valid, the last one is 2106-02-07 06:28:15.
// ----------------------------------------------------------------------------
module epoch_seconds_to_datetime import etd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] unix_seconds
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [11:0] year, [15:12] month,
                                      // [20:16] day_of_month, [25:21] hour,
                                      // [31:26] minute, [37:32] second,
                                      // [39:38] zero
);

  localparam int unsigned NSTG  = 6;
  localparam int unsigned OUT_W = 40;

  // stage 1 input register, stages 2..5 in the submodules, stage 6 output
  logic [NSTG:1]     vld_d, vld_q;
  logic [NSTG:1]     rdy;
  etd_adv_t          adv;

  logic [SECS_W-1:0] secs_q;
  logic [TOD_W-1:0]  tod;
  logic [DNUM_W-1:0] dnum;

  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [MDAY_W-1:0]  mday;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  logic [OUT_W-1:0]   out_d, out_q;

  // ready ripples back: a stage may load when empty or when it drains
  always_comb begin
    rdy[NSTG] = !vld_q[NSTG] || m_axis_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[1]) begin
      vld_d[1] = s_axis_tvalid;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign adv.s2 = rdy[2];
  assign adv.s3 = rdy[3];
  assign adv.s4 = rdy[4];
  assign adv.s5 = rdy[5];

  // input register
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      secs_q <= s_axis_tdata;
    end
  end

  // stages 2, 3: day count and seconds of day
  etd_split u_split (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .secs_i (secs_q),
    .tod_o  (tod),
    .dnum_o (dnum)
  );

  // stages 4, 5: time of day
  etd_time u_time (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .tod_i    (tod),
    .hour_o   (hour),
    .minute_o (minute),
    .second_o (second)
  );

  // stages 4, 5: year and day of year; month search feeds the output register
  etd_date u_date (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .dnum_i  (dnum),
    .year_o  (year),
    .month_o (month),
    .mday_o  (mday)
  );

  // output register
  assign out_d = {2'b00, second, minute, hour, mday, month, year};

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG]) begin
      out_q <= out_d;
    end
  end

  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = vld_q[NSTG];
  assign m_axis_tdata  = out_q;

endmodule

/* hw/rtl/etd_split.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etd_split: seconds to whole days and seconds of day
// Two stages: reciprocal multiply for the day count, then remainder and the
// adjusted day number used by the year split.
// ----------------------------------------------------------------------------
module etd_split import etd_pkg::*; (
  input  logic              clk_i,
  input  etd_adv_t          adv_i,
  input  logic [SECS_W-1:0] secs_i,
  output logic [TOD_W-1:0]  tod_o,
  output logic [DNUM_W-1:0] dnum_o
);

  localparam int unsigned XW = SECS_W - DAY_SHIFT;
  localparam int unsigned PW = XW + DAY_RECIP_W;

  logic [XW-1:0]        x_d, x_q;
  logic [DAY_SHIFT-1:0] lo_d, lo_q;
  logic [DAYS_W-1:0]    days_d, days_q;
  logic [PW-1:0]        prod;

  logic [XW-1:0]        dmul;
  logic [XW-1:0]        rem;
  logic [DAYS_W-1:0]    dadj;
  logic [TOD_W-1:0]     tod_d, tod_q;
  logic [DNUM_W-1:0]    dnum_d, dnum_q;

  // stage 2: days = (secs >> 7) / 675
  assign x_d    = secs_i[SECS_W-1:DAY_SHIFT];
  assign lo_d   = secs_i[DAY_SHIFT-1:0];
  assign prod   = PW'(x_d) * PW'(DAY_RECIP);
  assign days_d = prod[DAY_RECIP_SH +: DAYS_W];

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      x_q    <= x_d;
      lo_q   <= lo_d;
      days_q <= days_d;
    end
  end

  // stage 3: remainder rebuilds seconds of day; day number gets phantom leap day
  assign dmul   = XW'(days_q) * XW'(DAY_ODD);
  assign rem    = x_q - dmul;
  assign tod_d  = {rem[DAY_ODD_W-1:0], lo_q};
  assign dadj   = days_q + DAYS_W'(days_q >= DAY_2100_MAR1);
  assign dnum_d = {dadj, 2'b10};

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      tod_q  <= tod_d;
      dnum_q <= dnum_d;
    end
  end

  assign tod_o  = tod_q;
  assign dnum_o = dnum_q;

endmodule

/* hw/rtl/etd_time.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etd_time: seconds of day to hour, minute, second
// Hour and minutes-of-day by reciprocal multiply, then back-multiplied
// remainders give minute and second.
// ----------------------------------------------------------------------------
module etd_time import etd_pkg::*; (
  input  logic               clk_i,
  input  etd_adv_t           adv_i,
  input  logic [TOD_W-1:0]   tod_i,
  output logic [HOUR_W-1:0]  hour_o,
  output logic [MIN_W-1:0]   minute_o,
  output logic [SEC_W-1:0]   second_o
);

  localparam int unsigned PW = TOD_W + TRECIP_W;

  logic [PW-1:0]      hprod, mprod;
  logic [HOUR_W-1:0]  hour_d, hour4_q;
  logic [TMIN_W-1:0]  tm_d, tm_q;
  logic [TOD_W-1:0]   tod_q;

  logic [TOD_W-1:0]   tm60;
  logic [TOD_W-1:0]   sec_full;
  logic [TMIN_W-1:0]  h60;
  logic [TMIN_W-1:0]  min_full;
  logic [HOUR_W-1:0]  hour_q;
  logic [MIN_W-1:0]   minute_q;
  logic [SEC_W-1:0]   second_q;

  // stage 4
  assign hprod  = PW'(tod_i) * PW'(HOUR_RECIP);
  assign mprod  = PW'(tod_i) * PW'(MIN_RECIP);
  assign hour_d = hprod[HOUR_RECIP_SH +: HOUR_W];
  assign tm_d   = mprod[MIN_RECIP_SH +: TMIN_W];

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      tod_q   <= tod_i;
      tm_q    <= tm_d;
      hour4_q <= hour_d;
    end
  end

  // stage 5
  assign tm60     = TOD_W'(tm_q) * TOD_W'(SIXTY);
  assign sec_full = tod_q - tm60;
  assign h60      = TMIN_W'(hour4_q) * TMIN_W'(SIXTY);
  assign min_full = tm_q - h60;

  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      hour_q   <= hour4_q;
      minute_q <= min_full[MIN_W-1:0];
      second_q <= sec_full[SEC_W-1:0];
    end
  end

  assign hour_o   = hour_q;
  assign minute_o = minute_q;
  assign second_o = second_q;

endmodule

/* hw/rtl/etd_date.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etd_date: day number to year, month, day of month
// 4-year split by reciprocal multiply, then a month search over the start
// table; month and day come out combinationally from the stage 5 registers.
// ----------------------------------------------------------------------------
module etd_date import etd_pkg::*; (
  input  logic               clk_i,
  input  etd_adv_t           adv_i,
  input  logic [DNUM_W-1:0]  dnum_i,
  output logic [YEAR_W-1:0]  year_o,
  output logic [MONTH_W-1:0] month_o,
  output logic [MDAY_W-1:0]  mday_o
);

  localparam int unsigned PW = DNUM_W + Y4_RECIP_W;

  logic [PW-1:0]      yprod;
  logic [YOFF_W-1:0]  yoff_d, yoff_q;
  logic [DNUM_W-1:0]  dnum_q;

  logic [DNUM_W-1:0]  ymul;
  logic [DNUM_W-1:0]  rem;
  logic [YEAR_W-1:0]  year_d, year_q;
  logic [DOY_W-1:0]   doy_d, doy_q;
  logic               leap_d, leap_q;

  logic [DOY_W-1:0]   thr;
  logic [DOY_W-1:0]   base;
  logic [DOY_W-1:0]   dom;

  // stage 4: years since 1970
  assign yprod  = PW'(dnum_i) * PW'(Y4_RECIP);
  assign yoff_d = yprod[Y4_RECIP_SH +: YOFF_W];

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      yoff_q <= yoff_d;
      dnum_q <= dnum_i;
    end
  end

  // stage 5: day of year; leap when calendar year is a multiple of four
  assign ymul   = DNUM_W'(yoff_q) * DNUM_W'(DAYS_4Y);
  assign rem    = dnum_q - ymul;
  assign doy_d  = rem[2 +: DOY_W];
  assign leap_d = (yoff_q[1:0] == 2'b10);
  assign year_d = EPOCH_YEAR + YEAR_W'(yoff_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      year_q <= year_d;
      doy_q  <= doy_d;
      leap_q <= leap_d;
    end
  end

  // month search: last month whose first day is not past doy
  always_comb begin
    month_o = MONTH_W'(1);
    base    = '0;
    thr     = '0;
    for (int i = 1; i < 12; i++) begin
      thr = MONTH_START[i] + DOY_W'(leap_q && (i >= 2));
      if (doy_q >= thr) begin
        month_o = MONTH_W'(i + 1);
        base    = thr;
      end
    end
    dom    = doy_q - base + DOY_W'(1);
    mday_o = dom[MDAY_W-1:0];
  end

  assign year_o = year_q;

endmodule
